>>> src/assert_macros.svh
// Assertion macros shared by the view depth range finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define VDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define VDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/vdr_pkg.sv
// Types, constants and helpers for the view depth range finder.
package vdr_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        point_radius;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] near_plane;
    logic signed [31:0] far_plane;
  } bounds_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_DIR_X      = 3'd3,
    REG_DIR_Y      = 3'd4,
    REG_DIR_Z      = 3'd5,
    REG_NEAR_FLOOR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_t;

  localparam int unsigned StateW = 40;

  localparam logic signed [StateW-1:0] LowInit   = 40'sh7F_FFFF_FFFF;
  localparam logic signed [StateW-1:0] HighInit  = 40'sd0;
  localparam logic signed [StateW-1:0] OneQ16    = 40'sd65536;
  localparam logic signed [15:0]       DirZReset = 16'sd16384;
  localparam logic [30:0]              FloorReset = 31'd655;

  // Saturate a 40-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [StateW-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sh00_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/vdr_stream_if.sv
// Valid/ready channel carrying one word of a generic payload type.
interface vdr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/view_depth_range_finder.sv
// Top level of the view depth range finder: near/far bounds along a view axis.
//
// Usage:
//   point_i  - one word per point: pos_x/y/z (signed Q16.16), point_radius
//              (Q16.16) and last_point. A run of points ends on last_point.
//   bounds_o - one word per run: near_plane and far_plane (signed Q16.16),
//              emitted after the point flagged last_point.
//   cfg_i    - register writes (index, value), always ready. Write only
//              while the block is idle.
// Depth is (p - origin) . dir with dir in Q2.14, floored to Q16.16. The run
// keeps min(depth - radius) and max(depth + radius); on the last point far
// gets +1.0 if equal to near, near is raised to near_floor, both saturate.
// Timing: a point is registered on accept, its depth and the min/max update
// are computed from the input register, and the last point's result word
// loads into the output register and raises bounds_o.valid. Throughput is
// one point per cycle while no last point waits on a held result, set by the
// min/max update loop (three 33x16 multiplies, a 51-bit sum and two compares).
// Stall: a held result stops only a last point, which waits in the input
// register and holds point_i off; ordinary points keep flowing. Reset clears
// the pipeline, the running bounds and the registers (direction +z, floor 655).
module view_depth_range_finder
  import vdr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vdr_stream_if.sink           point_i,
  vdr_stream_if.source         bounds_o,
  vdr_stream_if.sink           cfg_i
);

`include "assert_macros.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] org_x_q, org_y_q, org_z_q;
  logic signed [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic [30:0]        floor_q;
  cfg_t               cfg_word;

  assign cfg_word    = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= DirZReset;
      floor_q <= FloorReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_word.index)
        REG_ORIGIN_X:   org_x_q <= cfg_word.value;
        REG_ORIGIN_Y:   org_y_q <= cfg_word.value;
        REG_ORIGIN_Z:   org_z_q <= cfg_word.value;
        REG_DIR_X:      dir_x_q <= cfg_word.value[15:0];
        REG_DIR_Y:      dir_y_q <= cfg_word.value[15:0];
        REG_DIR_Z:      dir_z_q <= cfg_word.value[15:0];
        REG_NEAR_FLOOR: floor_q <= cfg_word.value[30:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic   s1_valid_q;
  point_t s1_q;
  logic   s1_adv, s1_fire, in_fire;

  // a non-last point never waits; a last point waits for a free output slot
  assign s1_adv        = !s1_q.last_point || !bounds_o.valid || bounds_o.ready;
  assign s1_fire       = s1_valid_q && s1_adv;
  assign point_i.ready = !s1_valid_q || s1_adv;
  assign in_fire       = point_i.valid && point_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (point_i.ready) begin
      s1_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= point_i.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Depth and running bounds
  // ---------------------------------------------------------------------------
  logic signed [32:0]       dx, dy, dz;
  logic signed [48:0]       px, py, pz;
  logic signed [50:0]       dot_sum;
  logic signed [36:0]       depth;
  logic signed [StateW-1:0] radius, pt_lo, pt_hi;
  logic signed [StateW-1:0] low_q, high_q, low_nx, high_nx;
  logic signed [StateW-1:0] near_v, far_v, floor_ext;

  assign dx = 33'(s1_q.pos_x) - 33'(org_x_q);
  assign dy = 33'(s1_q.pos_y) - 33'(org_y_q);
  assign dz = 33'(s1_q.pos_z) - 33'(org_z_q);

  assign px = 49'(dx) * 49'(dir_x_q);
  assign py = 49'(dy) * 49'(dir_y_q);
  assign pz = 49'(dz) * 49'(dir_z_q);

  assign dot_sum = 51'(px) + 51'(py) + 51'(pz);
  assign depth   = dot_sum[50:14];  // arithmetic shift, floors toward -inf

  assign radius = $signed({9'd0, s1_q.point_radius});
  assign pt_lo  = 40'(depth) - radius;
  assign pt_hi  = 40'(depth) + radius;

  assign low_nx  = (pt_lo < low_q)  ? pt_lo : low_q;
  assign high_nx = (pt_hi > high_q) ? pt_hi : high_q;

  assign floor_ext = $signed({9'd0, floor_q});

  always_comb begin
    near_v = low_nx;
    far_v  = high_nx;
    if (low_nx == high_nx) begin
      far_v = high_nx + OneQ16;
    end
    if (low_nx < floor_ext) begin
      near_v = floor_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowInit;
      high_q <= HighInit;
    end else if (s1_fire) begin
      if (s1_q.last_point) begin
        low_q  <= LowInit;
        high_q <= HighInit;
      end else begin
        low_q  <= low_nx;
        high_q <= high_nx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic    out_valid_q;
  bounds_t out_q;
  logic    res_load;

  assign res_load = s1_fire && s1_q.last_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (bounds_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q.near_plane <= sat32(near_v);
      out_q.far_plane  <= sat32(far_v);
    end
  end

  assign bounds_o.valid = out_valid_q;
  assign bounds_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `VDR_ASSERT(a_last_gives_word, clk_i, rst_ni,
              res_load |=> out_valid_q,
              "last point did not produce a result word")
  `VDR_ASSERT(a_run_restart, clk_i, rst_ni,
              res_load |=> (low_q == LowInit) && (high_q == HighInit),
              "running bounds not restarted after a run")
  `VDR_ASSERT(a_near_above_floor, clk_i, rst_ni,
              out_valid_q |-> (40'(out_q.near_plane) >= floor_ext),
              "near plane below floor")
  `VDR_ASSERT_ALWAYS(a_high_nonneg, clk_i,
                     !high_q[StateW-1],
                     "running high went negative")

endmodule
